// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SAB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SAB_ASSERT(lbl, prop, msg)
`define SAB_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/sab64_pkg.sv -----
// types and constants of the selectable alphabet base64 codec
package sab64_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ALPHA_LEN = 64;
  localparam int unsigned N_SYM     = 4;
  localparam int unsigned SLOT_W    = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  table_id;
    logic [5:0]  entry_index;
    logic [31:0] data_word;
  } sab64_in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [3:0]  invalid_mask;
  } sab64_out_t;

  typedef struct packed {
    logic load_we;
    logic start;
    logic issue;
    logic out_load;
  } sab64_cmd_t;

  typedef struct packed {
    logic table_ok;
    logic last;
    logic out_busy;
  } sab64_stat_t;

endpackage

// ----- hdl/sab64_dpath.sv -----
// datapath: alphabet memory, read sequencing, search and regrouping, result register
module sab64_dpath #(
  parameter int unsigned NUM_ALPHABETS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sab64_pkg::sab64_in_t   in_data_i,
  input  sab64_pkg::sab64_cmd_t  cmd_i,
  output sab64_pkg::sab64_stat_t stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sab64_pkg::sab64_out_t  out_data_o
);
  import sab64_pkg::*;

  localparam int unsigned DEPTH = NUM_ALPHABETS * ALPHA_LEN;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [SYM_W-1:0] mem_q [DEPTH];
  logic [SYM_W-1:0] rdata_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic             dec_q;
  logic [3:0]       tbl_q;
  logic [31:0]      word_q;
  logic [IDX_W-1:0] cnt_q;

  logic [SYM_W-1:0] val_q [N_SYM];
  logic [N_SYM-1:0] found_q;

  logic [IDX_W-1:0] rd_idx;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [SYM_W-1:0] sym   [N_SYM];
  logic [SYM_W-1:0] e     [N_SYM];
  logic [SYM_W-1:0] d0, d1, d2;
  logic [N_SYM-1:0] mask;

  sab64_out_t out_q;
  logic       out_valid_q;

  assign stat_o.table_ok = ({1'b0, in_data_i.table_id} < 5'(NUM_ALPHABETS));
  assign stat_o.last     = dec_q ? (cnt_q == IDX_W'(ALPHA_LEN - 1))
                                 : (cnt_q == IDX_W'(N_SYM - 1));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // encode index by slot, decode walks the whole alphabet
  always_comb begin
    case (cnt_q[SLOT_W-1:0])
      2'd0:    rd_idx = word_q[23:18];
      2'd1:    rd_idx = word_q[17:12];
      2'd2:    rd_idx = word_q[11:6];
      default: rd_idx = word_q[5:0];
    endcase
    if (dec_q) begin
      rd_idx = cnt_q;
    end
  end

  assign raddr = AW'({tbl_q, rd_idx});
  assign waddr = AW'({in_data_i.table_id, in_data_i.entry_index});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem_q[waddr] <= in_data_i.data_word[SYM_W-1:0];
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dec_q  <= (in_data_i.cmd == OP_DECODE);
      tbl_q  <= in_data_i.table_id;
      word_q <= in_data_i.data_word;
    end
    rd_idx_q <= cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N_SYM; n++) begin
      sym[n] = word_q[(N_SYM - 1 - n) * SYM_W +: SYM_W];
      e[n]   = found_q[n] ? val_q[n] : sym[n];
    end
  end

  // search hits, then matched indices or encoded symbols
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (cmd_i.start) begin
      found_q <= '0;
    end else if (rd_vld_q && dec_q) begin
      for (int n = 0; n < N_SYM; n++) begin
        if (!found_q[n] && (rdata_q == sym[n])) begin
          found_q[n] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int n = 0; n < N_SYM; n++) begin
        if (dec_q) begin
          if (!found_q[n] && (rdata_q == sym[n])) begin
            val_q[n] <= {2'b00, rd_idx_q};
          end
        end else if (rd_idx_q[SLOT_W-1:0] == SLOT_W'(n)) begin
          val_q[n] <= rdata_q;
        end
      end
    end
  end

  // regroup with sign extension of unmatched symbols
  assign d0 = {e[0][5:0], 2'b00}  | {{4{e[1][7]}}, e[1][7:4]};
  assign d1 = {e[1][3:0], 4'b0000} | {{2{e[2][7]}}, e[2][7:2]};
  assign d2 = {e[2][1:0], 6'b000000} | e[3];

  always_comb begin
    for (int n = 0; n < N_SYM; n++) begin
      mask[N_SYM - 1 - n] = !found_q[n];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (dec_q) begin
        out_q.result_word  <= {8'h00, d0, d1, d2};
        out_q.invalid_mask <= mask;
      end else begin
        out_q.result_word  <= {val_q[0], val_q[1], val_q[2], val_q[3]};
        out_q.invalid_mask <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/sab64_ctrl.sv -----
// controller: item acceptance and read sequencing state machine
module sab64_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_cmd_i,
  output logic                   in_ready_o,
  input  sab64_pkg::sab64_stat_t stat_i,
  output sab64_pkg::sab64_cmd_t  cmd_o
);
  import sab64_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && stat_i.table_ok) begin
          if (in_cmd_i == OP_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else if (in_cmd_i == OP_ENCODE || in_cmd_i == OP_DECODE) begin
            cmd_o.start = 1'b1;
            state_d     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/selectable_alphabet_base64_codec_unit.sv -----
// top level of the selectable alphabet base64 codec
//
// input channel (in_valid_i / in_ready_o / in_data_i) takes load, encode and
// decode items; output channel (out_valid_o / out_ready_i / out_data_o) gives
// one result per encode or decode item, none for loads or ignored items.
// a load item is written when accepted; the next item may follow at once.
// encode: 4 memory reads, then the result register is loaded and only then
// is the next item taken.
// decode: 64 memory reads, one alphabet entry per cycle compared against all
// four symbols at once, then the result register is loaded and only then is
// the next item taken.
// the alphabet memory has a single read port; one item is worked on at a time
// and in_ready_o is high only between items.
// a finished result waits in the output register while the next item is
// accepted and worked on; if the receiver stalls, the next result holds in
// the datapath until the register frees, adding the stall cycles.
// reset clears control state only; alphabet memory has no clearing pass and
// entries read before being loaded give undefined symbols.
`include "assert_macros.svh"
module selectable_alphabet_base64_codec_unit #(
  parameter int unsigned NUM_ALPHABETS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sab64_pkg::sab64_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sab64_pkg::sab64_out_t out_data_o
);
  import sab64_pkg::*;

  sab64_cmd_t  ctl_cmd;
  sab64_stat_t dp_stat;

  sab64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  sab64_dpath #(
    .NUM_ALPHABETS (NUM_ALPHABETS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `SAB_ASSERT(a_start_blocks, ctl_cmd.start |=> !in_ready_o, "item taken while busy")
  `SAB_NEVER(a_no_overwrite, ctl_cmd.out_load && out_valid_o && !out_ready_i, "result lost")
  `SAB_NEVER(a_issue_start, ctl_cmd.issue && (ctl_cmd.start || ctl_cmd.load_we), "cmd clash")

endmodule

// ----- tb/sab64_checker.sv -----
// checker for the base64 codec: predicts every result and compares it with the output channel
`timescale 1ns / 1ps
module sab64_checker #(
  parameter int unsigned NUM_ALPHABETS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  sab64_pkg::sab64_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  sab64_pkg::sab64_out_t out_data_i,
  output int                    mismatch_cnt_o,
  output int                    pending_o
);
  import sab64_pkg::*;

  localparam int unsigned STORE_DEPTH = NUM_ALPHABETS * ALPHA_LEN;
  localparam int          PRINT_LIMIT = 100;

  logic [7:0] alpha_mem [STORE_DEPTH];
  sab64_out_t codec_results_q [$];
  sab64_out_t oldest;
  int         mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PRINT_LIMIT) begin
      $display("%0t ns: %s differs: got %h, want %h", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] alpha_sym(input logic [3:0] tbl, input logic [5:0] idx);
    return alpha_mem[int'(tbl) * ALPHA_LEN + int'(idx)];
  endfunction

  function automatic sab64_out_t encode_result(input logic [3:0] tbl,
                                               input logic [31:0] bytes);
    sab64_out_t r;
    r.result_word  = {alpha_sym(tbl, bytes[23:18]), alpha_sym(tbl, bytes[17:12]),
                      alpha_sym(tbl, bytes[11:6]), alpha_sym(tbl, bytes[5:0])};
    r.invalid_mask = '0;
    return r;
  endfunction

  function automatic sab64_out_t decode_result(input logic [3:0] tbl,
                                               input logic [31:0] syms);
    logic [31:0] val [N_SYM];
    logic [7:0]  s;
    logic [7:0]  d0, d1, d2;
    bit          hit;
    sab64_out_t  r;
    r.invalid_mask = '0;
    for (int n = 0; n < N_SYM; n++) begin
      s      = syms[31 - 8 * n -: 8];
      hit    = 1'b0;
      // unmatched symbol keeps its sign-extended raw value
      val[n] = {{24{s[7]}}, s};
      // scan downward so the lowest matching index wins
      for (int k = ALPHA_LEN - 1; k >= 0; k--) begin
        if (alpha_sym(tbl, 6'(k)) == s) begin
          hit    = 1'b1;
          val[n] = 32'(k);
        end
      end
      if (!hit) r.invalid_mask[3 - n] = 1'b1;
    end
    d0 = 8'((val[0] << 2) | (val[1] >> 4));
    d1 = 8'((val[1] << 4) | (val[2] >> 2));
    d2 = 8'((val[2] << 6) | val[3]);
    r.result_word = {8'h00, d0, d1, d2};
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_results_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (codec_results_q.size() == 0) begin
          report_mismatch("unexpected result_word", out_data_i.result_word, '0);
        end else begin
          oldest = codec_results_q.pop_front();
          if (out_data_i.result_word !== oldest.result_word) begin
            report_mismatch("result_word", out_data_i.result_word, oldest.result_word);
          end
          if (out_data_i.invalid_mask !== oldest.invalid_mask) begin
            report_mismatch("invalid_mask", 32'(out_data_i.invalid_mask),
                            32'(oldest.invalid_mask));
          end
        end
      end
      if (in_valid_i && in_ready_i && int'(in_data_i.table_id) < NUM_ALPHABETS) begin
        case (in_data_i.cmd)
          OP_LOAD: begin
            alpha_mem[int'(in_data_i.table_id) * ALPHA_LEN + int'(in_data_i.entry_index)] =
              in_data_i.data_word[7:0];
          end
          OP_ENCODE: begin
            codec_results_q = {codec_results_q,
                               encode_result(in_data_i.table_id, in_data_i.data_word)};
          end
          OP_DECODE: begin
            codec_results_q = {codec_results_q,
                               decode_result(in_data_i.table_id, in_data_i.data_word)};
          end
          default: begin
          end
        endcase
      end
      pending_o <= codec_results_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top: alphabet loads, encode and decode stimulus and the final verdict
`timescale 1ns / 1ps
module tb_top;
  import sab64_pkg::*;

  localparam int unsigned NUM_ALPHABETS = 16;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int          TOTAL_ITEMS   = 1800;
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_CYCLES  = 150;
  localparam int          FILL_EVERY    = 30;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  sab64_in_t  in_data   = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  sab64_out_t out_data;
  int         mismatch_cnt;
  int         pending;

  logic [7:0] alpha_shadow [NUM_ALPHABETS][ALPHA_LEN];
  bit         table_full [NUM_ALPHABETS];
  int         items_sent   = 0;
  int         burst_left   = 0;
  int         quiet_cycles = 0;
  bit         hold_req     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  selectable_alphabet_base64_codec_unit #(
    .NUM_ALPHABETS(NUM_ALPHABETS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  sab64_checker #(
    .NUM_ALPHABETS(NUM_ALPHABETS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] tbl,
                           input logic [5:0] idx, input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (cmd == OP_LOAD && int'(tbl) < NUM_ALPHABETS) alpha_shadow[tbl][idx] = word[7:0];
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, table_id: tbl, entry_index: idx, data_word: word};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // distinct symbols, random bytes, or a few heavily repeated symbols
  task automatic fill_table(input logic [3:0] tbl, input int style);
    logic [7:0] base, stride, sym;
    base   = 8'($urandom);
    stride = 8'($urandom) | 8'h01;
    for (int k = 0; k < ALPHA_LEN; k++) begin
      case (style)
        0:       sym = base + stride * 8'(k);
        1:       sym = 8'($urandom);
        default: sym = base + 8'($urandom_range(0, 7));
      endcase
      send_item(OP_LOAD, tbl, 6'(k), {24'($urandom), sym});
    end
    table_full[tbl] = 1'b1;
  endtask

  function automatic logic [3:0] pick_full_table();
    logic [3:0] t;
    t = 4'($urandom_range(0, NUM_ALPHABETS - 1));
    while (!table_full[t]) t = 4'($urandom_range(0, NUM_ALPHABETS - 1));
    return t;
  endfunction

  initial begin
    int         iter, roll, unloaded;
    logic [3:0] t;
    logic [31:0] syms;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < ALPHA_LEN; k++) begin
      send_item(OP_LOAD, 4'd0, 6'(k), 32'((37 * k + 5) & 63));
    end
    for (int k = 0; k < ALPHA_LEN; k++) begin
      send_item(OP_LOAD, 4'd15, 6'(k), {24'hA5A5A5, 8'hC0 | 8'(k & 7)});
    end
    table_full[0]  = 1'b1;
    table_full[15] = 1'b1;

    send_item(OP_ENCODE, 4'd0, 6'd0, 32'h0000_0000);
    send_item(OP_ENCODE, 4'd0, 6'd63, 32'h00FF_FFFF);
    send_item(OP_ENCODE, 4'd0, 6'd21, 32'hA55A_C33C);
    send_item(OP_ENCODE, 4'd15, 6'd0, 32'h0012_3456);
    send_item(OP_DECODE, 4'd0, 6'd0, {alpha_shadow[0][0], alpha_shadow[0][63],
                                      alpha_shadow[0][31], alpha_shadow[0][32]});
    // unmatched symbols, negative then positive raw values
    send_item(OP_DECODE, 4'd0, 6'd0, 32'h80FF_C0BF);
    send_item(OP_DECODE, 4'd0, 6'd0, 32'h407F_556A);
    send_item(OP_DECODE, 4'd0, 6'd0, {alpha_shadow[0][5], 8'h9C, alpha_shadow[0][60], 8'h41});
    // repeated symbols: lowest index wins
    send_item(OP_DECODE, 4'd15, 6'd0, 32'hC3C0_C700);
    send_item(OP_DECODE, 4'd15, 6'd63, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 4'd0, 6'd0, 32'h0012_3456);
    send_item(OP_LOAD, 4'd15, 6'd63, 32'hDEAD_BE5A);
    send_item(OP_ENCODE, 4'd15, 6'd0, 32'hFFFF_FFFF);
    send_item(OP_DECODE, 4'd15, 6'd0, 32'h5A5A_C75A);
    send_item(OP_LOAD, 4'd0, 6'd0, 32'h0000_00FF);
    send_item(OP_ENCODE, 4'd0, 6'd0, 32'h0000_0000);
    send_item(OP_DECODE, 4'd0, 6'd0, 32'hFFFF_FFFF);
    send_item(OP_DECODE, 4'd0, 6'd0, 32'h0505_0000);

    iter = 0;
    while (items_sent < TOTAL_ITEMS) begin
      iter++;
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
      if (iter == 150) hold_req = 1'b1;
      if (iter == 250) wait_results_drained();
      unloaded = 0;
      foreach (table_full[i]) if (!table_full[i]) unloaded++;
      if (iter % FILL_EVERY == 0 && unloaded > 0) begin
        t = 4'($urandom_range(0, NUM_ALPHABETS - 1));
        while (table_full[t]) t = 4'($urandom_range(0, NUM_ALPHABETS - 1));
        fill_table(t, $urandom_range(0, 2));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_item(OP_LOAD, 4'($urandom), 6'($urandom), $urandom);
        end else if (roll < 45) begin
          send_item(OP_ENCODE, pick_full_table(), 6'($urandom), $urandom);
        end else if (roll < 95) begin
          t = pick_full_table();
          for (int n = 0; n < N_SYM; n++) begin
            syms[31 - 8 * n -: 8] = ($urandom_range(0, 3) != 0) ?
              alpha_shadow[t][$urandom_range(0, ALPHA_LEN - 1)] : 8'($urandom);
          end
          send_item(OP_DECODE, t, 6'($urandom), syms);
        end else begin
          send_item(CMD_UNUSED, 4'($urandom), 6'($urandom), $urandom);
        end
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int run_len, stall_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (hold_req) begin
        stall_len = LONG_HOLD;
        hold_req  = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        stall_len = $urandom_range(20, 80);
      end else begin
        stall_len = $urandom_range(1, 3);
      end
      out_ready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sab64_pkg.sv
hdl/sab64_dpath.sv
hdl/sab64_ctrl.sv
hdl/selectable_alphabet_base64_codec_unit.sv
tb/sab64_checker.sv
tb/tb_top.sv
